// ===== rtl/u8u16_pkg.sv =====
// Shared types, codes and helper functions for the UTF-8 to UTF-16 converter.
package u8u16_pkg;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] RK_MARK  = 2'd0;
	localparam logic [1:0] RK_UNIT  = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	localparam logic [1:0] EK_BAD_LEAD   = 2'd0;
	localparam logic [1:0] EK_BAD_SECOND = 2'd1;
	localparam logic [1:0] EK_BAD_THIRD  = 2'd2;
	localparam logic [1:0] EK_TRUNCATED  = 2'd3;

	localparam logic [15:0] BOM_CODE  = 16'hFEFF;
	localparam logic [2:0]  LEAD2_TAG = 3'b110;
	localparam logic [3:0]  LEAD3_TAG = 4'b1110;
	localparam logic [1:0]  CONT_TAG  = 2'b10;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [1:0]  error_kind;
		logic [31:0] error_position;
		logic        is_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  need;
		logic [15:0] partial;
		logic [1:0]  total;
		logic        at_start;
		logic        mark_sent;
	} dec_state_t;

	function automatic out_item_t make_unit(input logic [1:0] rk, input logic [15:0] u,
			input logic be);
		out_item_t r;
		r = '0;
		r.result_kind = rk;
		if (be) begin
			r.first_byte  = u[15:8];
			r.second_byte = u[7:0];
		end else begin
			r.first_byte  = u[7:0];
			r.second_byte = u[15:8];
		end
		return r;
	endfunction

	function automatic out_item_t make_error(input logic [1:0] ek, input logic [31:0] pos);
		out_item_t r;
		r = '0;
		r.result_kind    = RK_ERROR;
		r.error_kind     = ek;
		r.error_position = pos;
		return r;
	endfunction

endpackage

// ===== rtl/utf8_to_utf16_stream_converter.sv =====
// Top level of the UTF-8 to UTF-16 stream converter.
// An item is registered, then decoded into the result queue when it has room.
// Throughput: one item per cycle while the queue has room; the first item can queue two results.
// Input stalls only while the four-entry result queue holds more than two results.
// Reset clears the sequence state, byte count and queue, and selects big-endian output.
module utf8_to_utf16_stream_converter
	import u8u16_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	in_item_t                 item_s1;
	logic                     valid_s1;
	logic                     big_endian_q;
	dec_state_t               state_q;
	dec_state_t               state_nxt;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_nxt;
	logic [1:0]               res_count;
	out_item_t                res0;
	out_item_t                res1;
	logic                     room;
	logic                     advance;

	assign advance    = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			pos_q   <= pos_nxt;
		end
	end

	u8u16_decode #(
		.POSITION_BITS(POSITION_BITS)
	) u_decode (
		.item      (item_s1),
		.st        (state_q),
		.pos       (pos_q),
		.big_endian(big_endian_q),
		.st_nxt    (state_nxt),
		.pos_nxt   (pos_nxt),
		.res_count (res_count),
		.res0      (res0),
		.res1      (res1)
	);

	u8u16_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(advance ? res_count : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (result_valid && !result_stall),
		.head      (result),
		.not_empty (result_valid),
		.room      (room)
	);

	// The mark is sent exactly once and is never taken back.
	a_mark_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(state_q.mark_sent))
		else $error("Mark flag cleared after being set.");

	// The first processed item always leaves at least the mark in the queue.
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !state_q.mark_sent |=> result_valid)
		else $error("No result queued after the first item.");

	// A pending sequence never needs more bytes than its total length.
	a_need_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.need == 2'd0 || state_q.need < state_q.total)
		else $error("Sequence byte count out of range.");

	// The byte count only grows while no reset is applied.
	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pos_q >= $past(pos_q))
		else $error("Byte count decreased.");

endmodule

// ===== rtl/u8u16_decode.sv =====
// Decoder step: next sequence state and up to two results for one item.
module u8u16_decode
	import u8u16_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  in_item_t                 item,
	input  dec_state_t               st,
	input  logic [POSITION_BITS-1:0] pos,
	input  logic                     big_endian,
	output dec_state_t               st_nxt,
	output logic [POSITION_BITS-1:0] pos_nxt,
	output logic [1:0]               res_count,
	output out_item_t                res0,
	output out_item_t                res1
);

	logic [POSITION_BITS-1:0] pos_inc;
	logic [15:0]              shifted;
	logic [7:0]               b;
	logic                     main_valid;
	out_item_t                main_res;
	out_item_t                mark_res;

	assign b       = item.data_byte;
	assign pos_inc = (pos == '1) ? pos : pos + 1'b1;
	assign shifted = {st.partial[9:0], b[5:0]};

	always_comb begin
		st_nxt           = st;
		st_nxt.mark_sent = 1'b1;
		pos_nxt          = pos;
		main_valid       = 1'b0;
		main_res         = '0;
		if (item.kind == KIND_END) begin
			if (st.need != 2'd0) begin
				main_valid = 1'b1;
				main_res   = make_error(EK_TRUNCATED, 32'(pos));
				st_nxt     = '0;
				st_nxt.mark_sent = 1'b1;
			end
		end else begin
			pos_nxt = pos_inc;
			if (st.need == 2'd0) begin
				priority if (b[7] == 1'b0) begin
					main_valid = 1'b1;
					main_res   = make_unit(RK_UNIT, {8'h00, b}, big_endian);
				end else if (b[7:5] == LEAD2_TAG) begin
					st_nxt.partial  = {11'd0, b[4:0]};
					st_nxt.need     = 2'd1;
					st_nxt.total    = 2'd2;
					st_nxt.at_start = 1'b0;
				end else if (b[7:4] == LEAD3_TAG) begin
					st_nxt.partial  = {12'd0, b[3:0]};
					st_nxt.need     = 2'd2;
					st_nxt.total    = 2'd3;
					st_nxt.at_start = (pos == '0);
				end else begin
					main_valid = 1'b1;
					main_res   = make_error(EK_BAD_LEAD, 32'(pos_inc));
				end
			end else if (b[7:6] == CONT_TAG) begin
				st_nxt.partial = shifted;
				st_nxt.need    = st.need - 2'd1;
				if (st.need == 2'd1) begin
					if (!(st.at_start && st.total == 2'd3 && shifted == BOM_CODE)) begin
						main_valid = 1'b1;
						main_res   = make_unit(RK_UNIT, shifted, big_endian);
					end
					st_nxt           = '0;
					st_nxt.mark_sent = 1'b1;
				end
			end else begin
				main_valid = 1'b1;
				main_res   = make_error((st.need == st.total - 2'd1) ? EK_BAD_SECOND
					: EK_BAD_THIRD, 32'(pos_inc));
				st_nxt           = '0;
				st_nxt.mark_sent = 1'b1;
			end
		end
	end

	always_comb begin
		mark_res  = make_unit(RK_MARK, BOM_CODE, big_endian);
		res_count = {1'b0, !st.mark_sent} + {1'b0, main_valid};
		res0      = st.mark_sent ? main_res : mark_res;
		res1      = main_res;
		res0.is_last = (res_count == 2'd1);
		res1.is_last = 1'b1;
	end

endmodule

// ===== rtl/u8u16_res_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
module u8u16_res_fifo
	import u8u16_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  out_item_t  push0,
	input  out_item_t  push1,
	input  logic       pop,
	output out_item_t  head,
	output logic       not_empty,
	output logic       room
);

	out_item_t  mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (count_q != 3'd0);
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_count;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_count} - {2'b00, pop};
		end
	end

endmodule

// ===== tb/tb_utf8_to_utf16_stream_converter.sv =====
// Testbench for the UTF-8 to UTF-16 converter: random and directed byte streams.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_stream_converter
	import u8u16_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;

	class utf16_scoreboard;
		bit          big_endian = 1'b1;
		logic [1:0]  need = '0;
		logic [15:0] partial = '0;
		logic [1:0]  total = '0;
		bit          seq_at_start = 1'b0;
		bit          mark_sent = 1'b0;
		logic [31:0] consumed = '0;
		out_item_t   pending_results[$];
		int          inputs_seen = 0;
		int          results_checked = 0;
		int          errors = 0;

		function out_item_t unit(logic [1:0] rk, logic [15:0] u);
			out_item_t r;
			r = '0;
			r.result_kind = rk;
			r.first_byte  = big_endian ? u[15:8] : u[7:0];
			r.second_byte = big_endian ? u[7:0] : u[15:8];
			return r;
		endfunction

		function out_item_t fault(logic [1:0] ek);
			out_item_t r;
			r = '0;
			r.result_kind    = RK_ERROR;
			r.error_kind     = ek;
			r.error_position = consumed;
			return r;
		endfunction

		function void clear_sequence();
			need = '0;
			partial = '0;
			total = '0;
			seq_at_start = 1'b0;
		endfunction

		function void note_input(in_item_t it);
			int          before_count;
			logic [7:0]  b;
			bit          started;
			before_count = pending_results.size();
			b = it.data_byte;
			inputs_seen++;
			if (!mark_sent) begin
				pending_results.push_back(unit(RK_MARK, BOM_CODE));
				mark_sent = 1'b1;
			end
			if (it.kind == KIND_END) begin
				if (need != 0) begin
					pending_results.push_back(fault(EK_TRUNCATED));
					clear_sequence();
				end
			end else begin
				started = (consumed == 0);
				if (consumed != '1)
					consumed++;
				if (need == 0) begin
					if (b[7] == 1'b0) begin
						pending_results.push_back(unit(RK_UNIT, {8'h00, b}));
					end else if (b[7:5] == LEAD2_TAG) begin
						partial = {11'b0, b[4:0]};
						need = 2'd1;
						total = 2'd2;
						seq_at_start = 1'b0;
					end else if (b[7:4] == LEAD3_TAG) begin
						partial = {12'b0, b[3:0]};
						need = 2'd2;
						total = 2'd3;
						seq_at_start = started;
					end else begin
						pending_results.push_back(fault(EK_BAD_LEAD));
					end
				end else if (b[7:6] == CONT_TAG) begin
					partial = {partial[9:0], b[5:0]};
					need--;
					if (need == 0) begin
						if (!(seq_at_start && total == 2'd3 && partial == BOM_CODE))
							pending_results.push_back(unit(RK_UNIT, partial));
						clear_sequence();
					end
				end else begin
					pending_results.push_back(fault((total - need == 2'd1) ?
						EK_BAD_SECOND : EK_BAD_THIRD));
					clear_sequence();
				end
			end
			if (pending_results.size() > before_count)
				pending_results[pending_results.size() - 1].is_last = 1'b1;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected, result_kind 0x%0h",
					got.result_kind);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			compare("result_kind", 32'(want.result_kind), 32'(got.result_kind));
			compare("first_byte", 32'(want.first_byte), 32'(got.first_byte));
			compare("second_byte", 32'(want.second_byte), 32'(got.second_byte));
			compare("error_kind", 32'(want.error_kind), 32'(got.error_kind));
			compare("error_position", want.error_position, got.error_position);
			compare("is_last", 32'(want.is_last), 32'(got.is_last));
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	int send_idle_pct = 17;
	int recv_idle_pct = 74;
	int cycle_count = 0;

	utf16_scoreboard sb = new();

	utf8_to_utf16_stream_converter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		result_stall = ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_utf8_to_utf16_stream_converter failed");
			$finish;
		end else if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
		end
	end

	function automatic in_item_t byte_item(logic [7:0] b);
		in_item_t it;
		it.kind = KIND_DATA;
		it.data_byte = b;
		return it;
	endfunction

	function automatic in_item_t end_item();
		in_item_t it;
		it.kind = KIND_END;
		it.data_byte = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		sb.note_input(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_order(bit be);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = be;
		@(posedge clk);
		sb.big_endian = be;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_random_sequence();
		int          sel;
		logic [10:0] cp;
		logic [15:0] u;
		logic [7:0]  b;
		sel = $urandom_range(0, 99);
		u = 16'($urandom);
		b = 8'($urandom);
		if (sel < 30) begin
			send_item(byte_item({1'b0, b[6:0]}));
		end else if (sel < 50) begin
			cp = u[10:0];
			send_item(byte_item({3'b110, cp[10:6]}));
			send_item(byte_item({2'b10, cp[5:0]}));
		end else if (sel < 72) begin
			if ($urandom_range(0, 15) == 0)
				u = BOM_CODE;
			send_item(byte_item({4'b1110, u[15:12]}));
			send_item(byte_item({2'b10, u[11:6]}));
			send_item(byte_item({2'b10, u[5:0]}));
		end else if (sel < 78) begin
			send_item(end_item());
		end else if (sel < 88) begin
			if ($urandom_range(0, 1) == 1) begin
				send_item(byte_item({4'b1110, u[15:12]}));
				if ($urandom_range(0, 1) == 1)
					send_item(byte_item({2'b10, u[11:6]}));
			end else begin
				send_item(byte_item({3'b110, u[10:6]}));
			end
			if ($urandom_range(0, 1) == 1) begin
				send_item(end_item());
			end else begin
				if (b[7:6] == CONT_TAG)
					b[6] = 1'b1;
				send_item(byte_item(b));
			end
		end else begin
			if ($urandom_range(0, 7) == 0)
				send_item(end_item());
			else
				send_item(byte_item(b));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(end_item());
		send_item(byte_item(8'hEF));
		send_item(byte_item(8'hBB));
		send_item(byte_item(8'hBF));
		send_item(byte_item(8'h00));
		send_item(byte_item(8'h7F));
		send_item(byte_item(8'hC2));
		send_item(byte_item(8'h80));
		send_item(byte_item(8'hEF));
		send_item(byte_item(8'hBF));
		send_item(byte_item(8'hBF));
		send_item(byte_item(8'hFF));
		send_item(byte_item(8'h80));
		send_item(byte_item(8'hC3));
		send_item(byte_item(8'h41));
		send_item(byte_item(8'hE2));
		send_item(byte_item(8'h82));
		send_item(byte_item(8'h41));
		send_item(byte_item(8'hE2));
		send_item(end_item());
		send_item(end_item());
		send_item(byte_item(8'hEF));
		send_item(byte_item(8'hBB));
		send_item(byte_item(8'hBF));

		set_order(1'b0);
		while (sb.inputs_seen < 400)
			send_random_sequence();

		send_idle_pct = 74;
		recv_idle_pct = 17;
		set_order(1'b1);
		while (sb.inputs_seen < 775)
			send_random_sequence();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_order(1'b0);
		while (sb.inputs_seen < 960)
			send_random_sequence();
		set_order(1'b1);
		while (sb.inputs_seen < 1150)
			send_random_sequence();

		wait_drained();
		$display("Checked %0d results from %0d input transfers in both byte orders,",
			sb.results_checked, sb.inputs_seen);
		$display("with malformed, truncated and mark sequences under varied idling.");
		if (sb.errors == 0)
			$display("tb_utf8_to_utf16_stream_converter passed");
		else
			$display("tb_utf8_to_utf16_stream_converter failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_res_fifo.sv
rtl/utf8_to_utf16_stream_converter.sv
tb/tb_utf8_to_utf16_stream_converter.sv
